### design/fwrt_pkg.sv
`timescale 1ns / 1ps

package fwrt_pkg;

	localparam int MaxRules = 16;

	localparam int AddrW   = 32;
	localparam int PortW   = 16;
	localparam int ModeW   = 2;
	localparam int StatusW = 3;
	localparam int IndexW  = 4;
	localparam int RuleW   = 2 * AddrW + 2 * PortW;

	typedef enum logic [ModeW-1:0] {
		ModeAdd  = 2'd0,
		ModeDel  = 2'd1,
		ModeConn = 2'd2,
		ModeRsvd = 2'd3
	} mode_t;

	typedef enum logic [StatusW-1:0] {
		StAdded    = 3'd0,
		StInvalid  = 3'd1,
		StDeleted  = 3'd2,
		StNotFound = 3'd3,
		StAccepted = 3'd4,
		StRejected = 3'd5,
		StFull     = 3'd6,
		StUnused   = 3'd7
	} status_t;

endpackage

### design/fwrt_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
module fwrt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16,
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/firewall_rule_table_unit.sv
`timescale 1ns / 1ps

// Ordered firewall rule table: add, delete and connection check on
// IPv4 address ranges paired with port ranges.
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; mode and the four range fields are sampled at that edge.
// Result channel: done is high for exactly one cycle, with status and
// rule_index valid in that cycle. The receiver cannot stall; every
// command produces exactly one result.
//
// Sequencing: add, an invalid range on add or delete, reserved mode or an
// empty table answer in the cycle after start. Check and delete scan the
// rule RAM, one entry read per cycle through the single comparator. A
// delete hit at position i then compacts the table, one entry moved per
// cycle through the same RAM port pair. busy is high while scanning or
// compacting.
//
// Reset clears the rule count; RAM contents are left as they are and are
// never read before being written.
module firewall_rule_table_unit #(
	parameter int MaxRules = fwrt_pkg::MaxRules
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [fwrt_pkg::ModeW-1:0]    mode,
	input  logic [fwrt_pkg::AddrW-1:0]    addr_first,
	input  logic [fwrt_pkg::AddrW-1:0]    addr_last,
	input  logic [fwrt_pkg::PortW-1:0]    port_first,
	input  logic [fwrt_pkg::PortW-1:0]    port_last,
	output logic                          done,
	output logic [fwrt_pkg::StatusW-1:0]  status,
	output logic [fwrt_pkg::IndexW-1:0]   rule_index
);

	import fwrt_pkg::*;

	// AW addresses the RAM, CW counts rules up to and including MaxRules
	localparam int AW = (MaxRules > 1) ? $clog2(MaxRules) : 1;
	localparam int CW = $clog2(MaxRules + 1);

	typedef enum logic [1:0] {
		Idle,
		Scan,
		Shift
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    cnt_q;       // stored rules
	logic [CW-1:0]    ptr_q;       // next RAM address to read
	logic             pend_s1;     // read data returns this cycle
	logic [CW-1:0]    idx_s1;      // address of the returning data
	logic [CW-1:0]    del_q;       // position of the deleted rule
	mode_t            mode_q;
	logic [AddrW-1:0] af_q, al_q;
	logic [PortW-1:0] pf_q, pl_q;
	logic             done_q;
	status_t          status_q;
	logic [IndexW-1:0] index_q;

	// RAM ports
	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [RuleW-1:0] ram_wdata, ram_rdata;

	logic             accept;
	logic             ordered;
	logic             more;
	logic             hit;
	logic [AddrW-1:0] r_af, r_al;
	logic [PortW-1:0] r_pf, r_pl;

	assign accept  = start && (state_q == Idle);
	assign ordered = (addr_first <= addr_last) && (port_first <= port_last);
	assign more    = (ptr_q < cnt_q);

	assign {r_af, r_al, r_pf, r_pl} = ram_rdata;

	// Shared compare unit: exact match for delete, coverage for check
	always_comb begin
		if (mode_q == ModeDel) begin
			hit = (r_af == af_q) && (r_al == al_q) && (r_pf == pf_q) && (r_pl == pl_q);
		end else begin
			hit = (af_q >= r_af) && (af_q <= r_al) && (pf_q >= r_pf) && (pf_q <= r_pl);
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = {addr_first, addr_last, port_first, port_last};
		if (accept && (mode_t'(mode) == ModeAdd) && ordered && (cnt_q < CW'(MaxRules))) begin
			ram_we = 1'b1;
		end else if ((state_q == Shift) && pend_s1) begin
			// move entry idx down by one
			ram_we    = 1'b1;
			ram_waddr = AW'(idx_s1 - CW'(1));
			ram_wdata = ram_rdata;
		end
	end

	assign ram_re    = (state_q != Idle) && more;
	assign ram_raddr = ptr_q[AW-1:0];

	fwrt_ram #(
		.Width (RuleW),
		.Depth (MaxRules)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= Idle;
			cnt_q    <= '0;
			ptr_q    <= '0;
			pend_s1  <= 1'b0;
			idx_s1   <= '0;
			del_q    <= '0;
			mode_q   <= ModeAdd;
			af_q     <= '0;
			al_q     <= '0;
			pf_q     <= '0;
			pl_q     <= '0;
			done_q   <= 1'b0;
			status_q <= StAdded;
			index_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				Idle: begin
					if (accept) begin
						mode_q  <= mode_t'(mode);
						af_q    <= addr_first;
						al_q    <= addr_last;
						pf_q    <= port_first;
						pl_q    <= port_last;
						ptr_q   <= '0;
						pend_s1 <= 1'b0;
						index_q <= '0;
						unique case (mode_t'(mode))
							ModeAdd: begin
								done_q <= 1'b1;
								if (!ordered) begin
									status_q <= StInvalid;
								end else if (cnt_q >= CW'(MaxRules)) begin
									status_q <= StFull;
								end else begin
									status_q <= StAdded;
									index_q  <= IndexW'(cnt_q);
									cnt_q    <= cnt_q + CW'(1);
								end
							end
							ModeDel: begin
								if (!ordered) begin
									done_q   <= 1'b1;
									status_q <= StInvalid;
								end else if (cnt_q == '0) begin
									done_q   <= 1'b1;
									status_q <= StNotFound;
								end else begin
									state_q <= Scan;
								end
							end
							ModeConn: begin
								if (cnt_q == '0) begin
									done_q   <= 1'b1;
									status_q <= StRejected;
								end else begin
									state_q <= Scan;
								end
							end
							ModeRsvd: begin
								done_q   <= 1'b1;
								status_q <= StUnused;
							end
						endcase
					end
				end

				Scan: begin
					// one read issued and one entry compared per cycle
					pend_s1 <= more;
					idx_s1  <= ptr_q;
					if (more) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (pend_s1 && hit) begin
						pend_s1 <= 1'b0;
						if (mode_q == ModeDel) begin
							del_q   <= idx_s1;
							ptr_q   <= idx_s1 + CW'(1);
							state_q <= Shift;
						end else begin
							done_q   <= 1'b1;
							status_q <= StAccepted;
							index_q  <= IndexW'(idx_s1);
							state_q  <= Idle;
						end
					end else if (pend_s1 && !more) begin
						// last entry compared, no match
						done_q   <= 1'b1;
						status_q <= (mode_q == ModeDel) ? StNotFound : StRejected;
						state_q  <= Idle;
					end
				end

				Shift: begin
					// read entry ptr while writing the previous one down
					pend_s1 <= more;
					idx_s1  <= ptr_q;
					if (more) begin
						ptr_q <= ptr_q + CW'(1);
					end else begin
						cnt_q    <= cnt_q - CW'(1);
						done_q   <= 1'b1;
						status_q <= StDeleted;
						index_q  <= IndexW'(del_q);
						state_q  <= Idle;
					end
				end

				default: begin
					state_q <= Idle;
				end
			endcase
		end
	end

	assign busy       = (state_q != Idle);
	assign done       = done_q;
	assign status     = status_q;
	assign rule_index = index_q;

`ifndef SYNTHESIS
	// a command always yields activity or an answer on the next cycle
	ast_start_answered: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done))
		else $error("command neither started nor answered");

	// results only appear once the sequencer is back to idle
	ast_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	ast_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MaxRules))
		else $error("rule count above table size");

	// a successful add grows the table by exactly one
	ast_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status_q == StAdded)) |-> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("add did not bump rule count");

	// a delete shrinks the table by exactly one
	ast_del_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status_q == StDeleted)) |-> (cnt_q == $past(cnt_q) - CW'(1)))
		else $error("delete did not drop rule count");
`endif

endmodule
